// ===== design/rithg_pkg.sv =====
// shared types and constants for the row top-hat and gradient filter
package rithg_pkg;

  localparam int ROW_PIXELS = 1024;
  localparam int ADDR_W     = $clog2(ROW_PIXELS);
  localparam int COL_W      = 10;
  localparam int PIX_W      = 8;
  localparam int SUM_W      = 18;
  localparam int CNT_W      = 11;
  localparam int HW_W       = 10;
  localparam int TH_W       = 17;
  localparam int QUO_W      = 26;
  localparam int DIV_CNT_W  = 5;
  localparam int NSLOT      = 7;
  localparam int STEP_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DAT_W  = 11;

  localparam logic [CNT_W-1:0] COLS_MIN   = CNT_W'(16);
  localparam logic [CNT_W-1:0] COLS_MAX   = CNT_W'(ROW_PIXELS);
  localparam logic [CNT_W-1:0] COLS_RESET = CNT_W'(640);

  // action codes
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EVAL = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GTHR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STHR = 2'd2;

  // prefix read slots, in read order
  localparam logic [STEP_W-1:0] SL_U    = 3'd0;
  localparam logic [STEP_W-1:0] SL_HI   = 3'd1;
  localparam logic [STEP_W-1:0] SL_LO   = 3'd2;
  localparam logic [STEP_W-1:0] SL_UPS  = 3'd3;
  localparam logic [STEP_W-1:0] SL_UMS  = 3'd4;
  localparam logic [STEP_W-1:0] SL_UP2S = 3'd5;
  localparam logic [STEP_W-1:0] SL_UM2S = 3'd6;
  localparam logic [STEP_W-1:0] SL_DONE = 3'd7;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUO_W - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_DIV
  } state_t;

endpackage

// ===== design/rithg_ram.sv =====
// generic simple dual-port ram with registered read
module rithg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/row_integral_tophat_gradient.sv =====
// top level of the row top-hat and lane-marking gradient filter
//
// usage
// - requests enter on start/busy: a request is taken at a clock edge with
//   start high and busy low. in_action selects a pixel load or a column
//   evaluation
// - a load writes the pixel and the running prefix sum into two rams and
//   busy stays low, so loads can arrive every cycle while no evaluation runs.
//   a load at column 0 restarts the sum and latches the row's half-width
// - an evaluation reads seven prefix entries and one pixel through the
//   single read port of each ram, forms the marks and runs a radix-2
//   restoring divide by s for the top-hat. busy stays high from
//   acceptance until the result strobe, so no new request is taken while
//   an evaluation is in progress
// - an evaluation of a column at or beyond the row length gives no result
//   and leaves busy low, so the next request may follow in the next cycle
// - each result is shown for one cycle with out_valid high; the receiver
//   cannot stall, and the next request may be taken in that same cycle
// - configuration writes go through cfg_valid/cfg_ready; cfg_ready is
//   always high and writes belong to idle periods only
// - reset (synchronous, active low) clears control state and the running
//   sum and sets the half-width to 1; ram contents stay undefined until written
module row_integral_tophat_gradient
  import rithg_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_action,
  input  logic [COL_W-1:0]            in_column,
  input  logic [PIX_W-1:0]            in_pixel,
  input  logic [CNT_W-1:0]            in_width_min,
  input  logic [CNT_W-1:0]            in_width_max,
  output logic                        out_valid,
  output logic [COL_W-1:0]            out_result_column,
  output logic signed [TH_W-1:0]      out_tophat_value,
  output logic                        out_tophat_valid,
  output logic                        out_gradient_mark,
  output logic                        out_symmetric_mark,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DAT_W-1:0]        cfg_data
);

  state_t state_r, state_nxt;

  // configuration
  logic [CNT_W-1:0] cols_cfg_r, cols_cfg_nxt;
  logic [PIX_W-1:0] gthr_r, gthr_nxt;
  logic [PIX_W-1:0] sthr_r, sthr_nxt;

  // row state
  logic [SUM_W-1:0] run_sum_r, run_sum_nxt;
  logic [HW_W-1:0]  half_w_r, half_w_nxt;

  // evaluation context
  logic [COL_W-1:0] u_r, u_nxt;
  logic [COL_W-1:0] hi_r, hi_nxt;
  logic [COL_W-1:0] lo_r, lo_nxt;
  logic             thv_r, thv_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SUM_W-1:0] slot_r [NSLOT];
  logic [SUM_W-1:0] slot_nxt [NSLOT];
  logic [PIX_W-1:0] pix_r, pix_nxt;
  logic             gmark_r, gmark_nxt;
  logic             smark_r, smark_nxt;

  // divider
  logic [QUO_W-1:0]     dq_r, dq_nxt;
  logic [HW_W-1:0]      rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] dcnt_r, dcnt_nxt;
  logic                 neg_r, neg_nxt;

  // result registers
  logic                   ov_r, ov_nxt;
  logic [COL_W-1:0]       ocol_r, ocol_nxt;
  logic [TH_W-1:0]        oth_r, oth_nxt;
  logic                   othv_r, othv_nxt;
  logic                   ogm_r, ogm_nxt;
  logic                   osm_r, osm_nxt;

  // ram ports
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [SUM_W-1:0]  sum_new;
  logic [SUM_W-1:0]  psum_rd;
  logic [PIX_W-1:0]  pix_rd;

  logic             accept;
  logic [CNT_W-1:0] cols;

  // half-width and window bounds for the incoming request
  logic [CNT_W:0]   wsum;
  logic [CNT_W-1:0] s_round;
  logic [CNT_W-1:0] s_odd;
  logic [HW_W-1:0]  s_new;
  logic [CNT_W:0]   two_s;
  logic [13:0]      six_s;
  logic [13:0]      u_p6s;
  logic             in_range;

  // arithmetic of the mark stage
  logic signed [SUM_W:0]   d_ups, d_up2s, d_ghl, d_rhu, d_lul;
  logic signed [SUM_W+2:0] num;
  logic [SUM_W+1:0]        mag;
  logic [CNT_W-1:0]        du_g, du_r, du_l;
  logic signed [9:0]       pg, ps;
  logic signed [21:0]      prod_g, prod_r, prod_l;

  // divider step
  logic [HW_W:0]    trial;
  logic             qbit;
  logic [QUO_W-1:0] q_fin;
  logic [QUO_W-1:0] q_signed;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign out_valid          = ov_r;
  assign out_result_column  = ocol_r;
  assign out_tophat_value   = $signed(oth_r);
  assign out_tophat_valid   = othv_r;
  assign out_gradient_mark  = ogm_r;
  assign out_symmetric_mark = osm_r;

  // row length clamped to the supported span
  always_comb begin
    if (cols_cfg_r < COLS_MIN) begin
      cols = COLS_MIN;
    end else if (cols_cfg_r > COLS_MAX) begin
      cols = COLS_MAX;
    end else begin
      cols = cols_cfg_r;
    end
  end

  // half-width: round((min+max)/4), forced odd, saturated
  always_comb begin
    wsum    = {1'b0, in_width_min} + {1'b0, in_width_max};
    s_round = CNT_W'((wsum + (CNT_W+1)'(2)) >> 2);
    s_odd   = s_round[0] ? s_round : s_round + CNT_W'(1);
    s_new   = (s_odd > CNT_W'(1023)) ? HW_W'(1023) : s_odd[HW_W-1:0];
  end

  // window bounds from the latched half-width
  always_comb begin
    two_s    = {half_w_r, 1'b0};
    six_s    = 14'(half_w_r) * 14'd6;
    u_p6s    = 14'(in_column) + six_s;
    in_range = {1'b0, in_column} < cols;
  end

  assign sum_new = (in_column == '0) ? SUM_W'(in_pixel) : run_sum_r + SUM_W'(in_pixel);
  assign wr_en   = accept && (in_action == ACT_LOAD);

  rithg_ram #(.WIDTH(SUM_W), .DEPTH(ROW_PIXELS)) u_prefix_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_column),
    .wr_data (sum_new),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (psum_rd)
  );

  rithg_ram #(.WIDTH(PIX_W), .DEPTH(ROW_PIXELS)) u_pixel_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_column),
    .wr_data (in_pixel),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (pix_rd)
  );

  // read address sequence; offsets wrap at the ram depth
  always_comb begin
    rd_en = (state_r == ST_READ) && (step_r != SL_DONE);
    unique case (step_r)
      SL_U:    rd_addr = u_r;
      SL_HI:   rd_addr = hi_r;
      SL_LO:   rd_addr = lo_r;
      SL_UPS:  rd_addr = ADDR_W'(u_r + half_w_r);
      SL_UMS:  rd_addr = ADDR_W'(u_r - half_w_r);
      SL_UP2S: rd_addr = ADDR_W'({1'b0, u_r} + two_s);
      SL_UM2S: rd_addr = ADDR_W'({1'b0, u_r} - two_s);
      default: rd_addr = u_r;
    endcase
  end

  // mark stage: exact comparisons by cross-multiplication
  always_comb begin
    d_ups  = $signed({1'b0, slot_r[SL_UPS]}) - $signed({1'b0, slot_r[SL_UMS]});
    d_up2s = $signed({1'b0, slot_r[SL_UP2S]}) - $signed({1'b0, slot_r[SL_UM2S]});
    num    = ($signed((SUM_W+3)'(d_ups)) <<< 1) - $signed((SUM_W+3)'(d_up2s));
    mag    = num[SUM_W+2] ? (SUM_W+2)'(-num) : (SUM_W+2)'(num);

    d_ghl  = $signed({1'b0, slot_r[SL_HI]}) - $signed({1'b0, slot_r[SL_LO]});
    d_rhu  = $signed({1'b0, slot_r[SL_HI]}) - $signed({1'b0, slot_r[SL_U]});
    d_lul  = $signed({1'b0, slot_r[SL_U]}) - $signed({1'b0, slot_r[SL_LO]});
    du_g   = {1'b0, hi_r} - {1'b0, lo_r} + CNT_W'(1);
    du_r   = {1'b0, hi_r} - {1'b0, u_r} + CNT_W'(1);
    du_l   = {1'b0, u_r} - {1'b0, lo_r} + CNT_W'(1);
    pg     = $signed({2'b00, pix_r}) - $signed({2'b00, gthr_r});
    ps     = $signed({2'b00, pix_r}) - $signed({2'b00, sthr_r});
    prod_g = 22'(pg) * $signed({11'b0, du_g});
    prod_r = 22'(ps) * $signed({11'b0, du_r});
    prod_l = 22'(ps) * $signed({11'b0, du_l});
  end

  // one restoring divide step by s
  always_comb begin
    trial    = {rem_r, dq_r[QUO_W-1]};
    qbit     = trial >= {1'b0, half_w_r};
    q_fin    = {dq_r[QUO_W-2:0], qbit};
    q_signed = neg_r ? -q_fin : q_fin;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_action == ACT_EVAL) && in_range) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (step_r == SL_DONE) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: state_nxt = ST_DIV;
      ST_DIV: begin
        if (dcnt_r == DIV_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and register updates
  always_comb begin
    cols_cfg_nxt = cols_cfg_r;
    gthr_nxt     = gthr_r;
    sthr_nxt     = sthr_r;
    run_sum_nxt  = run_sum_r;
    half_w_nxt   = half_w_r;
    u_nxt        = u_r;
    hi_nxt       = hi_r;
    lo_nxt       = lo_r;
    thv_nxt      = thv_r;
    step_nxt     = step_r;
    slot_nxt     = slot_r;
    pix_nxt      = pix_r;
    gmark_nxt    = gmark_r;
    smark_nxt    = smark_r;
    dq_nxt       = dq_r;
    rem_nxt      = rem_r;
    dcnt_nxt     = dcnt_r;
    neg_nxt      = neg_r;
    ov_nxt       = 1'b0;
    ocol_nxt     = ocol_r;
    oth_nxt      = oth_r;
    othv_nxt     = othv_r;
    ogm_nxt      = ogm_r;
    osm_nxt      = osm_r;

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_COLS: cols_cfg_nxt = cfg_data;
        REG_GTHR: gthr_nxt     = cfg_data[PIX_W-1:0];
        REG_STHR: sthr_nxt     = cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_action == ACT_LOAD)) begin
          run_sum_nxt = sum_new;
          if (in_column == '0) begin
            half_w_nxt = s_new;
          end
        end
        if (accept && (in_action == ACT_EVAL)) begin
          u_nxt    = in_column;
          step_nxt = SL_U;
          thv_nxt  = ({1'b0, in_column} >= two_s) &&
                     ((12'(in_column) + 12'(two_s)) < 12'(cols));
          hi_nxt   = (u_p6s >= 14'(cols - CNT_W'(1))) ? COL_W'(cols - CNT_W'(1))
                                                      : COL_W'(u_p6s);
          lo_nxt   = (14'(in_column) > six_s) ? COL_W'(14'(in_column) - six_s)
                                              : COL_W'(1);
        end
      end
      ST_READ: begin
        step_nxt = step_r + STEP_W'(1);
        if (step_r != SL_U) begin
          slot_nxt[step_r - STEP_W'(1)] = psum_rd;
        end
        if (step_r == SL_HI) begin
          pix_nxt = pix_rd;
        end
      end
      ST_CALC: begin
        gmark_nxt = prod_g > 22'(d_ghl);
        smark_nxt = (prod_r > 22'(d_rhu)) && (prod_l > 22'(d_lul));
        neg_nxt   = num[SUM_W+2];
        dq_nxt    = {mag, 6'b0};
        rem_nxt   = '0;
        dcnt_nxt  = '0;
      end
      ST_DIV: begin
        rem_nxt  = qbit ? HW_W'(trial - {1'b0, half_w_r}) : trial[HW_W-1:0];
        dq_nxt   = q_fin;
        dcnt_nxt = dcnt_r + DIV_CNT_W'(1);
        if (dcnt_r == DIV_LAST) begin
          ov_nxt   = 1'b1;
          ocol_nxt = u_r;
          oth_nxt  = thv_r ? q_signed[TH_W-1:0] : '0;
          othv_nxt = thv_r;
          ogm_nxt  = gmark_r;
          osm_nxt  = smark_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cols_cfg_r <= COLS_RESET;
      gthr_r     <= '0;
      sthr_r     <= '0;
      run_sum_r  <= '0;
      half_w_r   <= HW_W'(1);
      step_r     <= '0;
      dcnt_r     <= '0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cols_cfg_r <= cols_cfg_nxt;
      gthr_r     <= gthr_nxt;
      sthr_r     <= sthr_nxt;
      run_sum_r  <= run_sum_nxt;
      half_w_r   <= half_w_nxt;
      step_r     <= step_nxt;
      dcnt_r     <= dcnt_nxt;
      ov_r       <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    u_r     <= u_nxt;
    hi_r    <= hi_nxt;
    lo_r    <= lo_nxt;
    thv_r   <= thv_nxt;
    slot_r  <= slot_nxt;
    pix_r   <= pix_nxt;
    gmark_r <= gmark_nxt;
    smark_r <= smark_nxt;
    dq_r    <= dq_nxt;
    rem_r   <= rem_nxt;
    neg_r   <= neg_nxt;
    ocol_r  <= ocol_nxt;
    oth_r   <= oth_nxt;
    othv_r  <= othv_nxt;
    ogm_r   <= ogm_nxt;
    osm_r   <= osm_nxt;
  end

endmodule

// ===== design/rithg_chk.sv =====
// port-level checker for the row top-hat filter and its bind
module rithg_chk
  import rithg_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_action,
  input logic out_valid
);

  // a result strobe lasts one cycle
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // a load request never makes the block busy
  a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_action == ACT_LOAD)) |=> !busy)
    else $error("load request made the block busy");

  // a result follows an evaluation in progress
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without an evaluation in progress");

  // reset leaves the block idle with no result
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("block not idle after reset");

endmodule

bind row_integral_tophat_gradient rithg_chk u_rithg_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_action (in_action),
  .out_valid (out_valid)
);
